FILE: rtl/core/vu_meter_auto_range_peak_hold_macros.svh
// ---------------------------------------------------------------------------
// VU meter assertion macros
// Shared assertion forms for the VU meter checkers.
// ---------------------------------------------------------------------------
`ifndef VU_METER_AUTO_RANGE_PEAK_HOLD_MACROS_SVH
`define VU_METER_AUTO_RANGE_PEAK_HOLD_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VMAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vu meter check failed");

// next-cycle implication
`define VMAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vu meter check failed");

`endif

FILE: rtl/core/vmar_pkg.sv
// ---------------------------------------------------------------------------
// VU meter package
// Widths, constants, types and helpers shared by the VU meter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vmar_pkg;

    localparam int LED_COUNT = 32;

    localparam int SMP_W  = 11;
    localparam int LVL_W  = 10;
    localparam int DB_W   = 14;
    localparam int BAR_W  = 6;
    localparam int PER_W  = 10;
    localparam int ADJ_W  = 16;
    localparam int SINCE_W = 17;
    localparam int DIVR_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CAP   = (LED_COUNT < 63) ? LED_COUNT : 63;
    localparam int DVD_W = DB_W + $clog2(LED_COUNT + 1);
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // log2 datapath: Q30 mantissa, Q16 result
    localparam int M_W   = 31;
    localparam int P_W   = 2 * M_W;
    localparam int R_W   = 20;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] LOG_STEPS = STEP_W'(32);
    localparam logic [M_W-1:0] LOG_K = M_W'(394566);

    localparam logic [LVL_W-1:0] LVL_MAX = '1;
    localparam logic [PER_W-1:0] PER_MAX = '1;
    localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
    localparam logic [DB_W-1:0] DB_MAX = '1;

    localparam logic [PER_W-1:0] RST_PERIOD = PER_W'(50);
    localparam logic [DB_W-1:0] RST_FLOOR = DB_W'(128);
    localparam logic [ADJ_W-1:0] RST_ADJUST = ADJ_W'(1000);
    localparam logic [DB_W-1:0] RST_MIN_RANGE = DB_W'(512);
    localparam logic [DIVR_W-1:0] RST_DECAY = DIVR_W'(5);
    localparam logic [DB_W-1:0] RST_FULL_SCALE = DB_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD    = 3'd0,
        CFG_FLOOR     = 3'd1,
        CFG_ADJUST    = 3'd2,
        CFG_MIN_RANGE = 3'd3,
        CFG_DECAY     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOG,
        ST_MULK,
        ST_DB,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [M_W-1:0] a;
        logic [M_W-1:0] b;
    } mul_op_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // position of the highest set bit, 0 for zero
    function automatic logic [3:0] msb_pos(input logic [LVL_W-1:0] x);
        logic [3:0] n;
        n = '0;
        for (int i = 1; i < LVL_W; i++) begin
            if (x[i])
            begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/vmar_mul.sv
// ---------------------------------------------------------------------------
// VU meter shared multiplier
// Registered 31x31 multiplier used for log squaring and dB scaling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmar_mul
(
    input  logic                    clk,
    input  vmar_pkg::mul_op_t       op,
    output logic [vmar_pkg::P_W-1:0] prod_reg
);

    logic [vmar_pkg::P_W-1:0] prod_next;

    assign prod_next = vmar_pkg::P_W'(op.a) * vmar_pkg::P_W'(op.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

FILE: rtl/core/vmar_div.sv
// ---------------------------------------------------------------------------
// VU meter bar divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmar_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  vmar_pkg::div_req_t req,
    output vmar_pkg::div_rsp_t rsp
);

    logic [vmar_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [vmar_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [vmar_pkg::DB_W-1:0]   rem_reg, rem_next;
    logic [vmar_pkg::DB_W-1:0]   dvs_reg, dvs_next;
    logic [vmar_pkg::DB_W:0]     rem_sh;
    logic                        ge;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, dvd_reg[vmar_pkg::DVD_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        if (req.start)
        begin
            cnt_next = vmar_pkg::DCNT_W'(vmar_pkg::DVD_W);
            dvd_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[vmar_pkg::DVD_W-2:0], ge};
            rem_next = ge ? vmar_pkg::DB_W'(rem_sh - {1'b0, dvs_reg})
                          : vmar_pkg::DB_W'(rem_sh);
            if (cnt_reg == vmar_pkg::DCNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

FILE: rtl/core/vu_meter_auto_range_peak_hold.sv
// ---------------------------------------------------------------------------
// VU meter with auto range and peak hold
// Tracks per-period sample extremes, computes 20*log10(max/min) in Q8,
// scales it to an LED bar against an auto-ranging full scale, and keeps
// a slowly falling peak dot.
// ---------------------------------------------------------------------------
//  channel   signals                                  direction
//  in        in_valid/in_stall, sample_level, ms_tick  item in
//  out       out_valid/out_stall, bar_level, peak_dot,
//            db_value_q8                               item out
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
//  An item that does not close a period is taken without raising in_stall.
//  A closing item holds in_stall through setup (ST_INIT), both log2 values
//  through the shared multiplier (ST_LOG, hi and lo interleaved), dB
//  scaling (ST_MULK, ST_DB), the bar divider (start, DVD_W quotient bits,
//  result) and the output load (ST_DONE). With a zero full scale the
//  divider is skipped. in_stall stays high longer while a stalled result
//  blocks the output load. No clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vu_meter_auto_range_peak_hold
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [vmar_pkg::SMP_W-1:0]        sample_level,
    input  logic                              ms_tick,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vmar_pkg::BAR_W-1:0]        bar_level,
    output logic [vmar_pkg::BAR_W-1:0]        peak_dot,
    output logic [vmar_pkg::DB_W-1:0]         db_value_q8,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vmar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vmar_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vmar_pkg::state_t state_reg, state_next;

    logic [vmar_pkg::PER_W-1:0]   period_cfg_reg, period_cfg_next;
    logic [vmar_pkg::DB_W-1:0]    floor_cfg_reg, floor_cfg_next;
    logic [vmar_pkg::ADJ_W-1:0]   adjust_cfg_reg, adjust_cfg_next;
    logic [vmar_pkg::DB_W-1:0]    min_range_cfg_reg, min_range_cfg_next;
    logic [vmar_pkg::DIVR_W-1:0]  decay_cfg_reg, decay_cfg_next;

    logic                         open_reg, open_next;
    logic [vmar_pkg::PER_W-1:0]   elapsed_reg, elapsed_next;
    logic [vmar_pkg::SINCE_W-1:0] since_reg, since_next;
    logic [vmar_pkg::LVL_W-1:0]   high_reg, high_next;
    logic [vmar_pkg::LVL_W-1:0]   low_reg, low_next;
    logic [vmar_pkg::DB_W-1:0]    loudest_reg, loudest_next;
    logic [vmar_pkg::DB_W-1:0]    full_scale_reg, full_scale_next;
    logic [vmar_pkg::BAR_W-1:0]   held_reg, held_next;
    logic [vmar_pkg::DIVR_W-1:0]  phase_reg, phase_next;
    logic [vmar_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;

    logic [vmar_pkg::M_W-1:0]     m_hi_reg, m_hi_next, m_lo_reg, m_lo_next;
    logic [vmar_pkg::R_W-1:0]     r_hi_reg, r_hi_next, r_lo_reg, r_lo_next;
    logic                         zero_db_reg, zero_db_next;
    logic [vmar_pkg::DB_W-1:0]    db_reg, db_next;
    logic [vmar_pkg::BAR_W-1:0]   bar_reg, bar_next;
    logic [vmar_pkg::BAR_W-1:0]   out_bar_reg, out_bar_next;
    logic [vmar_pkg::BAR_W-1:0]   out_peak_reg, out_peak_next;
    logic [vmar_pkg::DB_W-1:0]    out_db_reg, out_db_next;

    vmar_pkg::mul_op_t            mul_op;
    logic [vmar_pkg::P_W-1:0]     prod_reg;
    vmar_pkg::div_req_t           div_req;
    vmar_pkg::div_rsp_t           div_rsp;

    // working values
    logic [vmar_pkg::LVL_W-1:0]   lo_eff;
    logic [3:0]                   n_hi, n_lo;
    logic [4:0]                   upd_k;
    logic [3:0]                   upd_bit;
    logic [31:0]                  sq;
    logic [vmar_pkg::M_W-1:0]     m_upd;
    logic                         r_set;
    logic [vmar_pkg::R_W-1:0]     d_log;
    logic [vmar_pkg::DB_W-1:0]    v_sat;
    logic [vmar_pkg::DB_W-1:0]    db_calc;
    logic [vmar_pkg::DB_W-1:0]    loud_max;
    logic [vmar_pkg::DIVR_W:0]    phase_inc;
    logic [vmar_pkg::DIVR_W-1:0]  decay_eff;
    logic [vmar_pkg::DIVR_W-1:0]  phase_new;

    vmar_mul u_mul
    (
        .clk      (clk),
        .op       (mul_op),
        .prod_reg (prod_reg)
    );

    vmar_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall    = (state_reg != vmar_pkg::ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign bar_level   = out_bar_reg;
    assign peak_dot    = out_peak_reg;
    assign db_value_q8 = out_db_reg;

    // config writes
    always_comb
    begin
        period_cfg_next    = period_cfg_reg;
        floor_cfg_next     = floor_cfg_reg;
        adjust_cfg_next    = adjust_cfg_reg;
        min_range_cfg_next = min_range_cfg_reg;
        decay_cfg_next     = decay_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (vmar_pkg::cfg_idx_t'(cfg_index))
                vmar_pkg::CFG_PERIOD:    period_cfg_next    = cfg_data[vmar_pkg::PER_W-1:0];
                vmar_pkg::CFG_FLOOR:     floor_cfg_next     = cfg_data[vmar_pkg::DB_W-1:0];
                vmar_pkg::CFG_ADJUST:    adjust_cfg_next    = cfg_data[vmar_pkg::ADJ_W-1:0];
                vmar_pkg::CFG_MIN_RANGE: min_range_cfg_next = cfg_data[vmar_pkg::DB_W-1:0];
                vmar_pkg::CFG_DECAY:     decay_cfg_next     = cfg_data[vmar_pkg::DIVR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lo_eff   = (low_reg == '0) ? vmar_pkg::LVL_W'(1) : low_reg;
        n_hi     = vmar_pkg::msb_pos(high_reg);
        n_lo     = vmar_pkg::msb_pos(lo_eff);
        upd_k    = 5'(step_reg - 1'b1);
        upd_bit  = ~upd_k[4:1];
        sq       = prod_reg[61:30];
        r_set    = sq[31];
        m_upd    = r_set ? sq[31:1] : sq[30:0];
        d_log    = r_hi_reg - r_lo_reg;
        v_sat    = (prod_reg[vmar_pkg::P_W-1:24 + vmar_pkg::DB_W] != '0) ? vmar_pkg::DB_MAX
                                                                         : prod_reg[37:24];
        db_calc  = (zero_db_reg || (v_sat < floor_cfg_reg)) ? '0 : v_sat;
        loud_max = (db_reg > loudest_reg) ? db_reg : loudest_reg;
        decay_eff = (decay_cfg_reg == '0) ? vmar_pkg::DIVR_W'(1) : decay_cfg_reg;
        phase_inc = {1'b0, phase_reg} + 1'b1;
        phase_new = (phase_inc >= {1'b0, decay_eff}) ? '0 : phase_inc[vmar_pkg::DIVR_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        open_next       = open_reg;
        elapsed_next    = elapsed_reg;
        since_next      = since_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        loudest_next    = loudest_reg;
        full_scale_next = full_scale_reg;
        held_next       = held_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        m_hi_next       = m_hi_reg;
        m_lo_next       = m_lo_reg;
        r_hi_next       = r_hi_reg;
        r_lo_next       = r_lo_reg;
        zero_db_next    = zero_db_reg;
        db_next         = db_reg;
        bar_next        = bar_reg;
        out_bar_next    = out_bar_reg;
        out_peak_next   = out_peak_reg;
        out_db_next     = out_db_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_op.a        = step_reg[0] ? m_lo_reg : m_hi_reg;
        mul_op.b        = step_reg[0] ? m_lo_reg : m_hi_reg;
        div_req.start    = 1'b0;
        div_req.dividend = vmar_pkg::DVD_W'(db_reg) * vmar_pkg::DVD_W'(vmar_pkg::LED_COUNT);
        div_req.divisor  = full_scale_reg;

        case (state_reg)
            vmar_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (ms_tick && (since_reg != vmar_pkg::SINCE_MAX))
                    begin
                        since_next = since_reg + 1'b1;
                    end
                    if (!open_reg)
                    begin
                        open_next    = 1'b1;
                        elapsed_next = '0;
                        high_next    = '0;
                        low_next     = vmar_pkg::LVL_MAX;
                    end
                    else if (ms_tick && (elapsed_reg != vmar_pkg::PER_MAX))
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                    if (!sample_level[vmar_pkg::SMP_W-1])
                    begin
                        if (sample_level[vmar_pkg::LVL_W-1:0] > high_next)
                        begin
                            high_next = sample_level[vmar_pkg::LVL_W-1:0];
                        end
                        if (sample_level[vmar_pkg::LVL_W-1:0] < low_next)
                        begin
                            low_next = sample_level[vmar_pkg::LVL_W-1:0];
                        end
                    end
                    if (elapsed_next >= period_cfg_reg)
                    begin
                        state_next = vmar_pkg::ST_INIT;
                    end
                end
            end

            vmar_pkg::ST_INIT:
            begin
                m_hi_next    = vmar_pkg::M_W'(high_reg) << (5'd30 - 5'(n_hi));
                m_lo_next    = vmar_pkg::M_W'(lo_eff) << (5'd30 - 5'(n_lo));
                r_hi_next    = vmar_pkg::R_W'({n_hi, 16'b0});
                r_lo_next    = vmar_pkg::R_W'({n_lo, 16'b0});
                zero_db_next = (high_reg <= lo_eff);
                step_next    = '0;
                state_next   = vmar_pkg::ST_LOG;
            end

            // even steps square hi, odd steps square lo; the registered product is used at the next step
            vmar_pkg::ST_LOG:
            begin
                if (step_reg != '0)
                begin
                    if (upd_k[0])
                    begin
                        m_lo_next = m_upd;
                        r_lo_next[upd_bit] = r_set;
                    end
                    else
                    begin
                        m_hi_next = m_upd;
                        r_hi_next[upd_bit] = r_set;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == vmar_pkg::LOG_STEPS)
                begin
                    state_next = vmar_pkg::ST_MULK;
                end
            end

            vmar_pkg::ST_MULK:
            begin
                mul_op.a   = vmar_pkg::M_W'(d_log);
                mul_op.b   = vmar_pkg::LOG_K;
                state_next = vmar_pkg::ST_DB;
            end

            vmar_pkg::ST_DB:
            begin
                db_next = db_calc;
                if (full_scale_reg == '0)
                begin
                    bar_next   = (db_calc != '0) ? vmar_pkg::BAR_W'(vmar_pkg::CAP) : '0;
                    state_next = vmar_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vmar_pkg::ST_DIV;
                end
            end

            // step is still nonzero from the log loop on entry
            vmar_pkg::ST_DIV:
            begin
                if (step_reg != '0)
                begin
                    div_req.start = 1'b1;
                    step_next     = '0;
                end
                else if (div_rsp.done)
                begin
                    bar_next = (div_rsp.quotient > vmar_pkg::DVD_W'(vmar_pkg::CAP))
                             ? vmar_pkg::BAR_W'(vmar_pkg::CAP)
                             : div_rsp.quotient[vmar_pkg::BAR_W-1:0];
                    state_next = vmar_pkg::ST_DONE;
                end
            end

            vmar_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    phase_next = phase_new;
                    if (since_reg <= vmar_pkg::SINCE_W'(adjust_cfg_reg))
                    begin
                        loudest_next = loud_max;
                    end
                    else
                    begin
                        since_next      = '0;
                        full_scale_next = (loud_max > min_range_cfg_reg) ? loud_max
                                                                         : min_range_cfg_reg;
                        loudest_next    = '0;
                    end
                    if (bar_reg > held_reg)
                    begin
                        held_next = bar_reg;
                    end
                    else if ((held_reg != '0) && (phase_new == '0))
                    begin
                        held_next = held_reg - 1'b1;
                    end
                    open_next      = 1'b0;
                    out_bar_next   = bar_reg;
                    out_peak_next  = held_next;
                    out_db_next    = db_reg;
                    out_valid_next = 1'b1;
                    state_next     = vmar_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vmar_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= vmar_pkg::ST_IDLE;
            period_cfg_reg    <= vmar_pkg::RST_PERIOD;
            floor_cfg_reg     <= vmar_pkg::RST_FLOOR;
            adjust_cfg_reg    <= vmar_pkg::RST_ADJUST;
            min_range_cfg_reg <= vmar_pkg::RST_MIN_RANGE;
            decay_cfg_reg     <= vmar_pkg::RST_DECAY;
            open_reg          <= 1'b0;
            elapsed_reg       <= '0;
            since_reg         <= '0;
            high_reg          <= '0;
            low_reg           <= vmar_pkg::LVL_MAX;
            loudest_reg       <= '0;
            full_scale_reg    <= vmar_pkg::RST_FULL_SCALE;
            held_reg          <= '0;
            phase_reg         <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            period_cfg_reg    <= period_cfg_next;
            floor_cfg_reg     <= floor_cfg_next;
            adjust_cfg_reg    <= adjust_cfg_next;
            min_range_cfg_reg <= min_range_cfg_next;
            decay_cfg_reg     <= decay_cfg_next;
            open_reg          <= open_next;
            elapsed_reg       <= elapsed_next;
            since_reg         <= since_next;
            high_reg          <= high_next;
            low_reg           <= low_next;
            loudest_reg       <= loudest_next;
            full_scale_reg    <= full_scale_next;
            held_reg          <= held_next;
            phase_reg         <= phase_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_hi_reg     <= m_hi_next;
        m_lo_reg     <= m_lo_next;
        r_hi_reg     <= r_hi_next;
        r_lo_reg     <= r_lo_next;
        zero_db_reg  <= zero_db_next;
        db_reg       <= db_next;
        bar_reg      <= bar_next;
        out_bar_reg  <= out_bar_next;
        out_peak_reg <= out_peak_next;
        out_db_reg   <= out_db_next;
    end

endmodule

FILE: rtl/core/vmar_checker.sv
// ---------------------------------------------------------------------------
// VU meter port checker
// Watches the top-level ports of the VU meter over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vu_meter_auto_range_peak_hold_macros.svh"

module vmar_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [vmar_pkg::BAR_W-1:0]    bar_level,
    input  logic [vmar_pkg::DB_W-1:0]     db_value_q8
);

    `VMAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `VMAR_ASSERT_NOW(a_bar_cap, out_valid, bar_level <= vmar_pkg::BAR_W'(vmar_pkg::CAP))
    `VMAR_ASSERT_NOW(a_silent_bar, out_valid && (db_value_q8 == '0), bar_level == '0)
    `VMAR_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall))

endmodule

bind vu_meter_auto_range_peak_hold vmar_checker u_vmar_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bar_level   (bar_level),
    .db_value_q8 (db_value_q8)
);

FILE: tb/vu_meter_auto_range_peak_hold_tb.sv
// ---------------------------------------------------------------------------
// VU meter auto range / peak hold testbench
// Streams microphone samples with millisecond ticks through the meter under
// randomized source gaps and sink stalls, predicts every period reading
// (dB, LED bar, peak dot) with an independent fixed-point model, and checks
// each reading field by field across several register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vu_meter_auto_range_peak_hold_tb;

    import vmar_pkg::*;

    localparam int RUN_LIMIT       = 1_500_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int MAX_REPORTS     = 10;
    localparam int LEVEL_TOP       = 1023;
    localparam int TICKS_SAT       = 131071;
    localparam int DB_CEIL         = 16383;
    localparam longint DB_PER_LOG2 = 394566;

    typedef struct packed {
        logic [SMP_W-1:0] level;
        logic             tick;
    } sample_t;

    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic [BAR_W-1:0] dot;
        logic [DB_W-1:0]  db;
    } reading_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [SMP_W-1:0]      sample_level = '0;
    logic                  ms_tick      = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [BAR_W-1:0]      bar_level;
    logic [BAR_W-1:0]      peak_dot;
    logic [DB_W-1:0]       db_value_q8;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    vu_meter_auto_range_peak_hold dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_level (sample_level),
        .ms_tick      (ms_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bar_level    (bar_level),
        .peak_dot     (peak_dot),
        .db_value_q8  (db_value_q8),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_t     pending_samples[$];
    reading_t    expected_readings[$];

    // meter model: register copies and period state
    int unsigned set_period    = RST_PERIOD;
    int unsigned set_floor     = RST_FLOOR;
    int unsigned set_adjust    = RST_ADJUST;
    int unsigned set_min_range = RST_MIN_RANGE;
    int unsigned set_decay     = RST_DECAY;

    bit          open_now            = 1'b0;
    int unsigned ticks_in_period     = 0;
    int unsigned ticks_since_rescale = 0;
    int unsigned top_level           = 0;
    int unsigned bottom_level        = LEVEL_TOP;
    int unsigned peak_db_seen        = 0;
    int unsigned scale_db            = RST_FULL_SCALE;
    int unsigned dot_pos             = 0;
    int unsigned dot_phase           = 0;

    int unsigned samples_sent    = 0;
    int unsigned readings_seen   = 0;
    int unsigned rescales        = 0;
    int unsigned zero_scale_bars = 0;
    int unsigned dot_falls       = 0;
    int unsigned settings_used   = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    sample_t     cur_sample;
    int unsigned idle_left       = 0;
    int unsigned calm_left       = 0;
    int unsigned stall_left      = 0;

    // log2 in Q16, mantissa kept in Q30 and squared bit by bit
    function automatic logic [63:0] log2_fix(input int unsigned x);
        int unsigned n;
        logic [63:0] m;
        logic [63:0] r;
        n = 0;
        if (x == 0)
        begin
            x = 1;
        end
        while (n < 10 && (x >> (n + 1)) != 0)
        begin
            n++;
        end
        m = 64'(x) << (30 - n);
        r = 64'(n) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int unsigned period_loudness(input int unsigned hi, input int unsigned lo);
        logic [63:0] span;
        logic [63:0] scaled;
        if (lo == 0)
        begin
            lo = 1;
        end
        if (hi <= lo)
        begin
            return 0;
        end
        span   = log2_fix(hi) - log2_fix(lo);
        scaled = (span * 64'(DB_PER_LOG2)) >> 24;
        if (scaled > DB_CEIL)
        begin
            scaled = DB_CEIL;
        end
        if (scaled < set_floor)
        begin
            return 0;
        end
        return 32'(scaled);
    endfunction

    function automatic void meter_step(input logic [SMP_W-1:0] lvl, input logic tk);
        int unsigned db;
        int unsigned bar;
        int unsigned div;
        reading_t    r;
        if (tk && ticks_since_rescale < TICKS_SAT)
        begin
            ticks_since_rescale++;
        end
        if (!open_now)
        begin
            open_now        = 1'b1;
            ticks_in_period = 0;
            top_level       = 0;
            bottom_level    = LEVEL_TOP;
        end
        else if (tk && ticks_in_period < LEVEL_TOP)
        begin
            ticks_in_period++;
        end
        if (lvl <= LEVEL_TOP)
        begin
            if (lvl > top_level)
            begin
                top_level = lvl;
            end
            if (lvl < bottom_level)
            begin
                bottom_level = lvl;
            end
        end
        if (ticks_in_period < set_period)
        begin
            return;
        end

        div = (set_decay == 0) ? 1 : set_decay;
        dot_phase++;
        if (dot_phase >= div)
        begin
            dot_phase = 0;
        end

        db = period_loudness(top_level, bottom_level);
        if (db > peak_db_seen)
        begin
            peak_db_seen = db;
        end

        if (scale_db == 0)
        begin
            bar = (db != 0) ? CAP : 0;
            if (db != 0)
            begin
                zero_scale_bars++;
            end
        end
        else
        begin
            bar = (db * LED_COUNT) / scale_db;
            if (bar > CAP)
            begin
                bar = CAP;
            end
        end

        // bar above uses the scale in force before renewal
        if (ticks_since_rescale > set_adjust)
        begin
            ticks_since_rescale = 0;
            scale_db     = (peak_db_seen > set_min_range) ? peak_db_seen : set_min_range;
            peak_db_seen = 0;
            rescales++;
        end

        if (bar > dot_pos)
        begin
            dot_pos = bar;
        end
        else if (dot_pos > 0 && dot_phase == 0)
        begin
            dot_pos--;
            dot_falls++;
        end

        open_now = 1'b0;
        r.bar = BAR_W'(bar);
        r.dot = BAR_W'(dot_pos);
        r.db  = DB_W'(db);
        expected_readings.push_back(r);
    endfunction

    // mostly short gaps, occasional long ones, and stretches with none
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // sample source
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            idle_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                meter_step(cur_sample.level, cur_sample.tick);
                samples_sent++;
            end
            if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                in_valid  <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                cur_sample    = pending_samples.pop_front();
                sample_level <= cur_sample.level;
                ms_tick      <= cur_sample.tick;
                in_valid     <= 1'b1;
                idle_left    <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // reading sink backpressure
    always @(posedge clk)
    begin : sink_stall
        int unsigned roll;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 20);
            end
            else if (roll < 90)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // register shadow for the model
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PERIOD:    set_period    = cfg_data[PER_W-1:0];
                CFG_FLOOR:     set_floor     = cfg_data[DB_W-1:0];
                CFG_ADJUST:    set_adjust    = cfg_data[ADJ_W-1:0];
                CFG_MIN_RANGE: set_min_range = cfg_data[DB_W-1:0];
                CFG_DECAY:     set_decay     = cfg_data[DIVR_W-1:0];
                default:       ;
            endcase
        end
    end

    // reading checker
    always @(posedge clk)
    begin : reading_check
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("[%0t] unexpected reading: bar %0d dot %0d db %0d",
                             $realtime, bar_level, peak_dot, db_value_q8);
                end
            end
            else
            begin
                want = expected_readings.pop_front();
                if (bar_level !== want.bar || peak_dot !== want.dot
                    || db_value_q8 !== want.db)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] reading %0d: exp bar %0d dot %0d db %0d, got bar %0d dot %0d db %0d",
                                 $realtime, readings_seen, want.bar, want.dot, want.db,
                                 bar_level, peak_dot, db_value_q8);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[%0t] timeout, %0d readings outstanding", $realtime,
                     expected_readings.size());
            $display("vu_meter_auto_range_peak_hold_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // upper data bits get junk half the time to exercise field masking
    task automatic load_config(input logic [PER_W-1:0] per, input logic [DB_W-1:0] flr,
                               input logic [ADJ_W-1:0] adj, input logic [DB_W-1:0] minr,
                               input logic [DIVR_W-1:0] dec);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_PERIOD, {junk[CFG_DATA_W-1:PER_W], per});
        write_reg(CFG_FLOOR, {junk[CFG_DATA_W-1:DB_W], flr});
        write_reg(CFG_ADJUST, adj);
        write_reg(CFG_MIN_RANGE, {junk[CFG_DATA_W-1:DB_W], minr});
        write_reg(CFG_DECAY, {junk[CFG_DATA_W-1:DIVR_W], dec});
        write_reg(CFG_IDX_W'(int'(CFG_DECAY) + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    task automatic add_sample(input int unsigned lvl, input bit tk);
        sample_t s;
        s.level = SMP_W'(lvl);
        s.tick  = tk;
        pending_samples.push_back(s);
    endtask

    task automatic queue_samples(input int n, input int unsigned tick_pct,
                                 input int unsigned spread, input int unsigned junk_pct);
        int unsigned center;
        int unsigned v;
        sample_t     s;
        center = $urandom_range(0, LEVEL_TOP);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                center = $urandom_range(0, LEVEL_TOP);
            end
            s.tick = ($urandom_range(1, 100) <= tick_pct);
            if ($urandom_range(1, 100) <= junk_pct)
            begin
                s.level = SMP_W'($urandom_range(LEVEL_TOP + 1, 2047));
            end
            else
            begin
                v = center + $urandom_range(0, spread);
                s.level = SMP_W'((v > LEVEL_TOP) ? LEVEL_TOP : v);
            end
            pending_samples.push_back(s);
        end
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned spread;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: periods of one tick
        load_config(1, 128, 2, 512, 2);
        add_sample(0, 1);    add_sample(1023, 1);    // zero minimum, full swing
        add_sample(2047, 1); add_sample(1024, 0); add_sample(1500, 1); // all ignored
        add_sample(300, 1);  add_sample(300, 1);     // max equals min
        add_sample(100, 1);  add_sample(101, 1);     // under the floor
        add_sample(2, 1);    add_sample(1, 1);
        add_sample(1023, 1); add_sample(1, 0); add_sample(700, 1);
        add_sample(700, 0);  add_sample(1023, 1);
        settle();

        // zero period: each sample closes its own period
        load_config(0, 128, 2, 512, 2);
        add_sample(512, 1); add_sample(0, 0); add_sample(1023, 1); add_sample(2047, 0);
        settle();

        load_config(3, 0, 20, 1, 1);
        queue_samples(200, 80, 1023, 10);
        settle();

        load_config(0, 16383, 1, 16383, 15);
        queue_samples(60, 50, 1023, 10);
        settle();

        // zero min range with renewal every period drives the scale to zero
        load_config(2, 128, 0, 0, 0);
        queue_samples(60, 90, 0, 5);
        queue_samples(100, 90, 1023, 5);
        settle();

        load_config(5, 128, 60, 512, 5);
        queue_samples(250, 95, 300, 5);
        settle();

        load_config(1023, 0, 65535, 16383, 15);
        queue_samples(1030, 100, 1023, 5);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case ($urandom_range(0, 2))
                0:       spread = 0;
                1:       spread = 30;
                default: spread = LEVEL_TOP;
            endcase
            load_config(PER_W'($urandom_range(0, 8)), DB_W'($urandom_range(0, 2000)),
                        ADJ_W'($urandom_range(0, 200)), DB_W'($urandom_range(0, 4000)),
                        DIVR_W'($urandom_range(0, 15)));
            queue_samples(50, $urandom_range(50, 100), spread, 10);
            settle();
        end

        $display("%0d samples over %0d register settings, %0d readings checked",
                 samples_sent, settings_used, readings_seen);
        $display("%0d range renewals, %0d bars on a zero scale, %0d peak-dot falls, %0d errors",
                 rescales, zero_scale_bars, dot_falls, error_count);
        if (error_count == 0)
        begin
            $display("vu_meter_auto_range_peak_hold_tb: clean");
        end
        else
        begin
            $display("vu_meter_auto_range_peak_hold_tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/vmar_pkg.sv
rtl/core/vmar_mul.sv
rtl/core/vmar_div.sv
rtl/core/vu_meter_auto_range_peak_hold.sv
rtl/core/vmar_checker.sv
tb/vu_meter_auto_range_peak_hold_tb.sv
